// ----- rtl/core/hfl_pkg.sv -----
// Shared types, field widths and codes of the handle free list allocator.
package hfl_pkg;

   localparam int DEFAULT_ENTRIES = 64;

   localparam int MODE_W       = 2;
   localparam int COUNT_W      = 16;
   localparam int HANDLE_W     = 16;
   localparam int NEW_HANDLE_W = 6;
   localparam int STATUS_W     = 2;
   localparam int ERR_W        = 2;

   localparam int QUEUE_DEPTH  = 2;

   localparam logic [MODE_W-1:0] MODE_GENERATE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_BOUND = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_INVALID   = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NO_MEMORY = 2'd2;

   typedef enum logic [1:0] {
      KIND_REPLY,
      KIND_GENERATE,
      KIND_RELEASE,
      KIND_QUERY
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [STATUS_W-1:0]   status;
      logic                  set_invalid;
   } cmd_ctl_type;

   typedef struct packed {
      logic init_busy;
      logic engine_idle;
   } back_stat_type;

   typedef struct packed {
      logic [NEW_HANDLE_W-1:0] new_handle;
      logic                    handle_valid;
      logic [STATUS_W-1:0]     status;
      logic                    is_bound;
      logic                    last;
      logic [ERR_W-1:0]        first_error;
   } rsp_word_type;

endpackage

// ----- rtl/core/hfl_channels.sv -----
// Valid/ready channel interfaces for request and response words.
interface hfl_req_if;
   import hfl_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [MODE_W-1:0]          mode;
   logic signed [COUNT_W-1:0]  count;
   logic [HANDLE_W-1:0]        handle;

   modport source (output valid, mode, count, handle, input ready);
   modport sink   (input valid, mode, count, handle, output ready);
endinterface

interface hfl_rsp_if;
   import hfl_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [NEW_HANDLE_W-1:0]  new_handle;
   logic                     handle_valid;
   logic [STATUS_W-1:0]      status;
   logic                     is_bound;
   logic                     last;
   logic [ERR_W-1:0]         first_error;

   modport source (output valid, new_handle, handle_valid, status, is_bound, last, first_error,
                   input ready);
   modport sink   (input valid, new_handle, handle_valid, status, is_bound, last, first_error,
                   output ready);
endinterface

// ----- rtl/core/hfl_front.sv -----
// Request decoder and short command queue in front of the allocator engine.
module hfl_front #(
   parameter int ENTRIES = hfl_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   hfl_req_if.sink                       req_ch,
   output logic                          cmd_valid,
   output hfl_pkg::cmd_ctl_type          cmd_ctl,
   output logic [hfl_pkg::COUNT_W-2:0]   cmd_count,
   output logic [$clog2(ENTRIES)-1:0]    cmd_index,
   input  logic                          cmd_pop
);
   import hfl_pkg::*;

   localparam int INDEX_W = $clog2(ENTRIES);
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam logic [HANDLE_W-1:0] ENTRY_LIMIT = HANDLE_W'(ENTRIES);

   cmd_ctl_type           q_ctl_ff   [QUEUE_DEPTH];
   logic [COUNT_W-2:0]    q_count_ff [QUEUE_DEPTH];
   logic [INDEX_W-1:0]    q_index_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;

   cmd_ctl_type           new_ctl;
   logic                  in_range;
   logic                  push;

   // Sort the request into a direct reply or a job for the engine.
   always_comb begin
      in_range            = req_ch.handle < ENTRY_LIMIT;
      new_ctl.kind        = KIND_REPLY;
      new_ctl.status      = STATUS_OK;
      new_ctl.set_invalid = 1'b0;
      unique case (req_ch.mode)
         MODE_GENERATE: begin
            if (req_ch.count[COUNT_W-1]) begin
               new_ctl.status      = STATUS_INVALID;
               new_ctl.set_invalid = 1'b1;
            end else if (req_ch.count != '0) begin
               new_ctl.kind = KIND_GENERATE;
            end
         end
         MODE_RELEASE: begin
            if (in_range && (req_ch.handle != '0)) begin
               new_ctl.kind = KIND_RELEASE;
            end else begin
               new_ctl.status = STATUS_NOT_BOUND;
            end
         end
         MODE_QUERY: begin
            if (in_range) begin
               new_ctl.kind = KIND_QUERY;
            end
         end
         default: begin
            new_ctl.kind = KIND_REPLY;
         end
      endcase
   end

   assign req_ch.ready = fill_ff != FILL_W'(QUEUE_DEPTH);
   assign push         = req_ch.valid && req_ch.ready;

   assign cmd_valid = fill_ff != '0;
   assign cmd_ctl   = q_ctl_ff[rd_ptr_ff];
   assign cmd_count = q_count_ff[rd_ptr_ff];
   assign cmd_index = q_index_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({push, cmd_pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ctl_ff[wr_ptr_ff]   <= new_ctl;
         q_count_ff[wr_ptr_ff] <= req_ch.count[COUNT_W-2:0];
         q_index_ff[wr_ptr_ff] <= req_ch.handle[INDEX_W-1:0];
      end
   end

endmodule

// ----- rtl/core/hfl_back.sv -----
// Allocator engine: link table, free list head, counters and response register.
module hfl_back #(
   parameter int ENTRIES = hfl_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  hfl_pkg::cmd_ctl_type          cmd_ctl,
   input  logic [hfl_pkg::COUNT_W-2:0]   cmd_count,
   input  logic [$clog2(ENTRIES)-1:0]    cmd_index,
   output logic                          cmd_pop,
   output hfl_pkg::back_stat_type        back_stat,
   hfl_rsp_if.source                     rsp_ch
);
   import hfl_pkg::*;

   localparam int INDEX_W = $clog2(ENTRIES);
   localparam int LINK_W  = INDEX_W + 1;
   localparam logic [LINK_W-1:0]  BOUND_MARK = LINK_W'(ENTRIES);
   localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(ENTRIES - 1);

   typedef enum logic [6:0] {
      S_INIT   = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_POP_RD = 7'b0000100,
      S_POP_WR = 7'b0001000,
      S_REV_RD = 7'b0010000,
      S_REV_WR = 7'b0100000,
      S_LOOK   = 7'b1000000
   } state_type;

   logic [LINK_W-1:0]   link_mem [ENTRIES];
   logic [LINK_W-1:0]   rd_data_ff;
   logic                mem_we;
   logic [INDEX_W-1:0]  mem_wa;
   logic [LINK_W-1:0]   mem_wd;
   logic [INDEX_W-1:0]  mem_ra;

   state_type           state_ff, state_in;
   logic [INDEX_W-1:0]  init_idx_ff, init_idx_in;
   logic [INDEX_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]   free_ff, free_in;
   logic [ERR_W-1:0]    sticky_ff, sticky_in;
   logic [LINK_W-1:0]   left_ff, left_in;
   logic [INDEX_W-1:0]  prev_ff, prev_in;
   logic [INDEX_W-1:0]  cur_ff, cur_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                is_rel_ff, is_rel_in;
   logic                out_valid_ff, out_valid_in;
   rsp_word_type        out_ff;

   logic                slot_free;
   logic                count_fits;
   logic                entry_bound;
   logic [INDEX_W-1:0]  next_link;
   logic                emit;
   rsp_word_type        emit_word;

   assign slot_free   = !out_valid_ff || rsp_ch.ready;
   assign count_fits  = {1'b0, cmd_count} <= COUNT_W'(free_ff);
   assign entry_bound = rd_data_ff == BOUND_MARK;
   // A link at or above the table size is taken as the end of the list.
   assign next_link   = (rd_data_ff >= BOUND_MARK) ? '0 : rd_data_ff[INDEX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      init_idx_in = init_idx_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      sticky_in   = sticky_ff;
      left_in     = left_ff;
      prev_in     = prev_ff;
      cur_in      = cur_ff;
      idx_in      = idx_ff;
      is_rel_in   = is_rel_ff;
      cmd_pop     = 1'b0;
      emit        = 1'b0;
      emit_word   = '0;
      mem_we      = 1'b0;
      mem_wa      = head_ff;
      mem_wd      = '0;
      mem_ra      = head_ff;

      unique case (state_ff)
         S_INIT: begin
            mem_we      = 1'b1;
            mem_wa      = init_idx_ff;
            mem_wd      = (init_idx_ff == LAST_INDEX) ? '0
                                                      : LINK_W'(init_idx_ff) + LINK_W'(1);
            init_idx_in = init_idx_ff + INDEX_W'(1);
            if (init_idx_ff == LAST_INDEX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            mem_ra = cmd_index;
            if (cmd_valid && slot_free) begin
               cmd_pop = 1'b1;
               unique case (cmd_ctl.kind)
                  KIND_REPLY: begin
                     emit             = 1'b1;
                     emit_word.status = cmd_ctl.status;
                     emit_word.last   = 1'b1;
                     if (cmd_ctl.set_invalid && (sticky_ff == ERR_NONE)) begin
                        sticky_in = ERR_INVALID;
                     end
                  end
                  KIND_GENERATE: begin
                     if (count_fits) begin
                        left_in  = LINK_W'(cmd_count);
                        state_in = S_POP_RD;
                     end else begin
                        prev_in  = '0;
                        cur_in   = head_ff;
                        state_in = S_REV_RD;
                     end
                  end
                  KIND_RELEASE, KIND_QUERY: begin
                     idx_in    = cmd_index;
                     is_rel_in = cmd_ctl.kind == KIND_RELEASE;
                     state_in  = S_LOOK;
                  end
               endcase
            end
         end
         S_POP_RD: begin
            mem_ra = head_ff;
            if (slot_free) begin
               state_in = S_POP_WR;
            end
         end
         S_POP_WR: begin
            mem_we                 = 1'b1;
            mem_wa                 = head_ff;
            mem_wd                 = BOUND_MARK;
            emit                   = 1'b1;
            emit_word.new_handle   = NEW_HANDLE_W'(head_ff);
            emit_word.handle_valid = 1'b1;
            emit_word.last         = left_ff == LINK_W'(1);
            head_in                = next_link;
            free_in                = free_ff - LINK_W'(1);
            left_in                = left_ff - LINK_W'(1);
            state_in               = (left_ff == LINK_W'(1)) ? S_IDLE : S_POP_RD;
         end
         S_REV_RD: begin
            mem_ra = cur_ff;
            if (cur_ff == '0) begin
               head_in          = prev_ff;
               emit             = 1'b1;
               emit_word.status = STATUS_NO_MEMORY;
               emit_word.last   = 1'b1;
               if (sticky_ff == ERR_NONE) begin
                  sticky_in = ERR_NO_MEMORY;
               end
               state_in = S_IDLE;
            end else begin
               state_in = S_REV_WR;
            end
         end
         S_REV_WR: begin
            mem_we   = 1'b1;
            mem_wa   = cur_ff;
            mem_wd   = LINK_W'(prev_ff);
            prev_in  = cur_ff;
            cur_in   = next_link;
            state_in = S_REV_RD;
         end
         S_LOOK: begin
            emit           = 1'b1;
            emit_word.last = 1'b1;
            if (is_rel_ff) begin
               if (entry_bound) begin
                  mem_we  = 1'b1;
                  mem_wa  = idx_ff;
                  mem_wd  = LINK_W'(head_ff);
                  head_in = idx_ff;
                  free_in = free_ff + LINK_W'(1);
               end else begin
                  emit_word.status = STATUS_NOT_BOUND;
               end
            end else begin
               emit_word.is_bound = entry_bound;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      emit_word.first_error = sticky_in;
      out_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_idx_ff  <= '0;
         head_ff      <= INDEX_W'(1);
         free_ff      <= LINK_W'(ENTRIES - 1);
         sticky_ff    <= ERR_NONE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         sticky_ff    <= sticky_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff   <= left_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      is_rel_ff <= is_rel_in;
      if (emit) begin
         out_ff <= emit_word;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= link_mem[mem_ra];
   end

   assign back_stat.init_busy   = state_ff == S_INIT;
   assign back_stat.engine_idle = state_ff == S_IDLE;

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.new_handle   = out_ff.new_handle;
   assign rsp_ch.handle_valid = out_ff.handle_valid;
   assign rsp_ch.status       = out_ff.status;
   assign rsp_ch.is_bound     = out_ff.is_bound;
   assign rsp_ch.last         = out_ff.last;
   assign rsp_ch.first_error  = out_ff.first_error;

endmodule

// ----- rtl/core/handle_free_list_allocator.sv -----
// Top level of the handle allocator over a linked free list in a table.
// Replies without table work (zero or negative count, bad handle) come straight from idle.
// Release and query read the entry's link, then reply; a batch pops one handle at a time,
// since each pop is a table read followed by a table write.
// Out of memory walks the free list once, reversing it, then replies.
// After reset a clearing pass over every entry rebuilds the chain; requests queue meanwhile.
module handle_free_list_allocator #(
   parameter int ENTRIES = hfl_pkg::DEFAULT_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   hfl_req_if.sink     req_ch,
   hfl_rsp_if.source   rsp_ch
);
   import hfl_pkg::*;

   // The front decodes each request word and parks it in a two-word command
   // queue, so a new request is taken while the engine is still busy with a
   // batch or while a response word waits at the output.
   logic                          cmd_valid;
   cmd_ctl_type                   cmd_ctl;
   logic [COUNT_W-2:0]            cmd_count;
   logic [$clog2(ENTRIES)-1:0]    cmd_index;
   logic                          cmd_pop;
   back_stat_type                 back_stat;

   hfl_front #(
      .ENTRIES (ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ctl   (cmd_ctl),
      .cmd_count (cmd_count),
      .cmd_index (cmd_index),
      .cmd_pop   (cmd_pop)
   );

   // The back end owns the link table. A generate batch pops one handle at a
   // time, a read of the head's link followed by marking it bound. When
   // the request asks for more handles than are free, the free list is
   // reversed in place, which is the same as popping everything and pushing
   // it back in pop order. Results go out through a single response register.
   hfl_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ctl   (cmd_ctl),
      .cmd_count (cmd_count),
      .cmd_index (cmd_index),
      .cmd_pop   (cmd_pop),
      .back_stat (back_stat),
      .rsp_ch    (rsp_ch)
   );

`ifndef SYNTH
   a_no_dispatch_in_init: assert property (@(posedge clock) disable iff (reset)
      back_stat.init_busy |-> !cmd_pop)
      else $error("command taken during the clearing pass");

   a_no_rsp_in_init: assert property (@(posedge clock) disable iff (reset)
      back_stat.init_busy |-> !rsp_ch.valid)
      else $error("response word during the clearing pass");

   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      cmd_valid && !cmd_pop |=> cmd_valid)
      else $error("queued command lost without dispatch");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> back_stat.engine_idle)
      else $error("command taken while the engine is busy");

   a_handle_word_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.handle_valid |-> (rsp_ch.status == STATUS_OK) && !rsp_ch.is_bound)
      else $error("handle word carries an error or query answer");
`endif

endmodule
